// ===== design/smx_pkg.sv =====
// Package for the SUBLEQ macro expander: widths, opcodes, register indexes,
// control word format, the microcode table and the dispatch table.
// No dependencies; every other design file refers to it by scoped names.
`default_nettype none

package smx_pkg;

  // Word and field widths.
  localparam int WORD_BITS     = 32;
  localparam int ADDR_BITS     = 31;
  localparam int ACTION_BITS   = 4;
  localparam int ARGC_BITS     = 2;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int UPC_BITS      = 5;

  // Program counter step per advancing control word.
  localparam logic [WORD_BITS-1:0] PC_STEP = WORD_BITS'(3);

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_ZERO_ADDR  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_START_ADDR = CFG_IDX_BITS'(1);

  // Macro opcodes.
  typedef enum logic [ACTION_BITS-1:0] {
    ACT_NOP    = 4'd0,
    ACT_SUBLEQ = 4'd1,
    ACT_SUB    = 4'd2,
    ACT_ADD    = 4'd3,
    ACT_JMP    = 4'd4,
    ACT_MOV    = 4'd5,
    ACT_BEQ    = 4'd6,
    ACT_NOT    = 4'd7,
    ACT_HALT   = 4'd8,
    ACT_DATA   = 4'd9
  } action_e;

  // Word source selects of the datapath.
  typedef enum logic [3:0] {
    SRC_ZERO,
    SRC_Z,
    SRC_A,
    SRC_B,
    SRC_C,
    SRC_PC,
    SRC_PC3,
    SRC_PC6,
    SRC_ONES
  } src_e;

  // Sequencer states.
  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_e;

  // One control word of the microprogram.
  typedef struct packed {
    logic adv;   // advance the program counter by three
    logic emit;  // load a triple into the result register
    logic done;  // last step of this macro
    logic bad;   // result flags an illegal argument count
    src_e sel_a;
    src_e sel_b;
    src_e sel_c;
  } ctrl_t;

  // Command from the sequencer to the datapath.
  typedef struct packed {
    logic  capture;  // latch the operands of a new macro
    logic  exec;     // the current control word takes effect
    ctrl_t ctrl;
  } seq_cmd_t;

  // Microprogram entry points.
  localparam logic [UPC_BITS-1:0] UA_NOP     = 5'd0;
  localparam logic [UPC_BITS-1:0] UA_SUB     = 5'd1;
  localparam logic [UPC_BITS-1:0] UA_MOV     = 5'd2;
  localparam logic [UPC_BITS-1:0] UA_ADD     = 5'd3;
  localparam logic [UPC_BITS-1:0] UA_BEQ     = 5'd6;
  localparam logic [UPC_BITS-1:0] UA_JMP     = 5'd10;
  localparam logic [UPC_BITS-1:0] UA_NOT     = 5'd11;
  localparam logic [UPC_BITS-1:0] UA_HALT    = 5'd12;
  localparam logic [UPC_BITS-1:0] UA_DATA0   = 5'd13;
  localparam logic [UPC_BITS-1:0] UA_DATA1   = 5'd14;
  localparam logic [UPC_BITS-1:0] UA_DATA2   = 5'd15;
  localparam logic [UPC_BITS-1:0] UA_DATA3   = 5'd16;
  localparam logic [UPC_BITS-1:0] UA_BAD     = 5'd17;
  localparam logic [UPC_BITS-1:0] UA_UNKNOWN = 5'd18;

  // Build one control word.
  function automatic ctrl_t cw(input logic adv, input logic emit, input logic done,
                               input logic bad, input src_e sa, input src_e sb,
                               input src_e sc);
    ctrl_t w;
    w.adv   = adv;
    w.emit  = emit;
    w.done  = done;
    w.bad   = bad;
    w.sel_a = sa;
    w.sel_b = sb;
    w.sel_c = sc;
    return w;
  endfunction

  // Microcode table. Move runs into the add sequence, and a three-operand
  // subleq shares the full data word.
  function automatic ctrl_t ucode_rom(input logic [UPC_BITS-1:0] upc);
    ctrl_t w;
    w = cw(1'b0, 1'b0, 1'b1, 1'b0, SRC_ZERO, SRC_ZERO, SRC_ZERO);
    case (upc)
      UA_NOP:   w = cw(1'b1, 1'b1, 1'b1, 1'b0, SRC_Z, SRC_Z, SRC_PC);
      UA_SUB:   w = cw(1'b1, 1'b1, 1'b1, 1'b0, SRC_A, SRC_B, SRC_PC);
      UA_MOV:   w = cw(1'b1, 1'b1, 1'b0, 1'b0, SRC_B, SRC_B, SRC_PC);
      UA_ADD:   w = cw(1'b1, 1'b1, 1'b0, 1'b0, SRC_A, SRC_Z, SRC_PC);
      5'd4:     w = cw(1'b1, 1'b1, 1'b0, 1'b0, SRC_Z, SRC_B, SRC_PC);
      5'd5:     w = cw(1'b1, 1'b1, 1'b1, 1'b0, SRC_Z, SRC_Z, SRC_PC);
      UA_BEQ:   w = cw(1'b1, 1'b1, 1'b0, 1'b0, SRC_A, SRC_Z, SRC_PC3);
      5'd7:     w = cw(1'b1, 1'b1, 1'b0, 1'b0, SRC_Z, SRC_Z, SRC_PC6);
      5'd8:     w = cw(1'b1, 1'b1, 1'b0, 1'b0, SRC_Z, SRC_Z, SRC_PC);
      5'd9:     w = cw(1'b1, 1'b1, 1'b1, 1'b0, SRC_Z, SRC_A, SRC_B);
      UA_JMP:   w = cw(1'b1, 1'b1, 1'b1, 1'b0, SRC_Z, SRC_Z, SRC_A);
      UA_NOT:   w = cw(1'b1, 1'b0, 1'b1, 1'b0, SRC_ZERO, SRC_ZERO, SRC_ZERO);
      UA_HALT:  w = cw(1'b1, 1'b1, 1'b1, 1'b0, SRC_ONES, SRC_ONES, SRC_ONES);
      UA_DATA0: w = cw(1'b1, 1'b1, 1'b1, 1'b0, SRC_ZERO, SRC_ZERO, SRC_ZERO);
      UA_DATA1: w = cw(1'b1, 1'b1, 1'b1, 1'b0, SRC_A, SRC_ZERO, SRC_ZERO);
      UA_DATA2: w = cw(1'b1, 1'b1, 1'b1, 1'b0, SRC_A, SRC_B, SRC_ZERO);
      UA_DATA3: w = cw(1'b1, 1'b1, 1'b1, 1'b0, SRC_A, SRC_B, SRC_C);
      UA_BAD:   w = cw(1'b0, 1'b1, 1'b1, 1'b1, SRC_ZERO, SRC_ZERO, SRC_ZERO);
      default:  w = cw(1'b0, 1'b0, 1'b1, 1'b0, SRC_ZERO, SRC_ZERO, SRC_ZERO);
    endcase
    return w;
  endfunction

  // Dispatch: the jump target for an opcode and its argument count.
  function automatic logic [UPC_BITS-1:0] dispatch(input logic [ACTION_BITS-1:0] act,
                                                   input logic [ARGC_BITS-1:0] argc);
    logic [UPC_BITS-1:0] t;
    t = UA_UNKNOWN;
    case (act)
      ACT_NOP:    t = (argc == 2'd0) ? UA_NOP : UA_BAD;
      ACT_SUBLEQ: t = (argc == 2'd2) ? UA_SUB : ((argc == 2'd3) ? UA_DATA3 : UA_BAD);
      ACT_SUB:    t = (argc == 2'd2) ? UA_SUB : UA_BAD;
      ACT_ADD:    t = (argc == 2'd2) ? UA_ADD : UA_BAD;
      ACT_JMP:    t = (argc == 2'd1) ? UA_JMP : UA_BAD;
      ACT_MOV:    t = (argc == 2'd2) ? UA_MOV : UA_BAD;
      ACT_BEQ:    t = (argc == 2'd2) ? UA_BEQ : UA_BAD;
      ACT_NOT:    t = (argc == 2'd1) ? UA_NOT : UA_BAD;
      ACT_HALT:   t = UA_HALT;
      ACT_DATA: begin
        case (argc)
          2'd0:    t = UA_DATA0;
          2'd1:    t = UA_DATA1;
          2'd2:    t = UA_DATA2;
          default: t = UA_DATA3;
        endcase
      end
      default:    t = UA_UNKNOWN;
    endcase
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== design/smx_if.sv =====
// Channel interfaces of the SUBLEQ macro expander: macro input, triple
// result and configuration write. Depends on smx_pkg for widths.
`default_nettype none

interface smx_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [smx_pkg::ACTION_BITS-1:0]      action;
  logic [smx_pkg::ARGC_BITS-1:0]        arg_count;
  logic signed [smx_pkg::WORD_BITS-1:0] operand_a;
  logic signed [smx_pkg::WORD_BITS-1:0] operand_b;
  logic signed [smx_pkg::WORD_BITS-1:0] operand_c;

  modport source (output valid, action, arg_count, operand_a, operand_b, operand_c,
                  input ready);
  modport sink (input valid, action, arg_count, operand_a, operand_b, operand_c,
                output ready);
endinterface

interface smx_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [smx_pkg::WORD_BITS-1:0] word_a;
  logic signed [smx_pkg::WORD_BITS-1:0] word_b;
  logic signed [smx_pkg::WORD_BITS-1:0] word_c;
  logic                                 last;
  logic                                 bad_args;

  modport source (output valid, word_a, word_b, word_c, last, bad_args, input ready);
  modport sink (input valid, word_a, word_b, word_c, last, bad_args, output ready);
endinterface

interface smx_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [smx_pkg::CFG_IDX_BITS-1:0]   index;
  logic [smx_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/smx_sequencer.sv =====
// Microcode sequencer: step counter, control word table and dispatch jump.
// Depends on smx_pkg for the control word format and the tables.
`default_nettype none

module smx_sequencer (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [smx_pkg::ACTION_BITS-1:0] action_i,
  input  wire logic [smx_pkg::ARGC_BITS-1:0]   arg_count_i,
  input  wire logic                            out_free_i,
  output smx_pkg::seq_cmd_t                    cmd_o
);

  smx_pkg::seq_state_e          state_q, state_d;
  logic [smx_pkg::UPC_BITS-1:0] upc_q, upc_d;
  smx_pkg::ctrl_t               ctrl;
  logic                         exec;

  // Current control word.
  assign ctrl = smx_pkg::ucode_rom(upc_q);

  // State and step counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smx_pkg::SEQ_IDLE;
      upc_q   <= '0;
    end else begin
      state_q <= state_d;
      upc_q   <= upc_d;
    end
  end

  // Next state: dispatch on a new macro, step on, or return to idle. A step
  // that emits waits until the result register can take the triple.
  always_comb begin
    state_d    = state_q;
    upc_d      = upc_q;
    exec       = 1'b0;
    in_ready_o = 1'b0;
    case (state_q)
      smx_pkg::SEQ_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = smx_pkg::SEQ_RUN;
          upc_d   = smx_pkg::dispatch(action_i, arg_count_i);
        end
      end
      smx_pkg::SEQ_RUN: begin
        exec = !ctrl.emit || out_free_i;
        if (exec) begin
          if (ctrl.done) begin
            state_d = smx_pkg::SEQ_IDLE;
          end else begin
            upc_d = upc_q + smx_pkg::UPC_BITS'(1);
          end
        end
      end
      default: begin
        state_d = smx_pkg::SEQ_IDLE;
      end
    endcase
  end

  assign cmd_o.capture = in_ready_o && in_valid_i;
  assign cmd_o.exec    = exec;
  assign cmd_o.ctrl    = ctrl;

endmodule

`default_nettype wire

// ===== design/smx_datapath.sv =====
// Datapath: configuration registers, program counter, operand latches, word
// selection and the result register. Depends on smx_pkg.
`default_nettype none

module smx_datapath (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire smx_pkg::seq_cmd_t                      cmd_i,
  output logic                                        out_free_o,
  input  wire logic signed [smx_pkg::WORD_BITS-1:0]   operand_a_i,
  input  wire logic signed [smx_pkg::WORD_BITS-1:0]   operand_b_i,
  input  wire logic signed [smx_pkg::WORD_BITS-1:0]   operand_c_i,
  input  wire logic                                   cfg_valid_i,
  input  wire logic [smx_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  wire logic [smx_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_ready_i,
  output logic signed [smx_pkg::WORD_BITS-1:0]        word_a_o,
  output logic signed [smx_pkg::WORD_BITS-1:0]        word_b_o,
  output logic signed [smx_pkg::WORD_BITS-1:0]        word_c_o,
  output logic                                        last_o,
  output logic                                        bad_args_o
);

  localparam int W = smx_pkg::WORD_BITS;
  localparam int A = smx_pkg::ADDR_BITS;

  logic [A-1:0] zero_q;
  logic [W-1:0] pc_q;
  logic [W-1:0] pc_d;
  logic [W-1:0] pc3, pc6;
  logic [W-1:0] z_word;
  logic [W-1:0] op_a_q, op_b_q, op_c_q;
  logic         out_valid_q;
  logic [W-1:0] word_a_q, word_b_q, word_c_q;
  logic         last_q, bad_q;
  logic         load_out;

  // Counter after this step's advance, and the forward branch targets.
  assign pc_d   = cmd_i.ctrl.adv ? (pc_q + smx_pkg::PC_STEP) : pc_q;
  assign pc3    = pc_d + smx_pkg::PC_STEP;
  assign pc6    = pc3 + smx_pkg::PC_STEP;
  assign z_word = W'(zero_q);

  // Word source select.
  function automatic logic [W-1:0] pick(input smx_pkg::src_e sel,
                                        input logic [W-1:0] z, input logic [W-1:0] a,
                                        input logic [W-1:0] b, input logic [W-1:0] c,
                                        input logic [W-1:0] p, input logic [W-1:0] p3,
                                        input logic [W-1:0] p6);
    logic [W-1:0] r;
    case (sel)
      smx_pkg::SRC_Z:    r = z;
      smx_pkg::SRC_A:    r = a;
      smx_pkg::SRC_B:    r = b;
      smx_pkg::SRC_C:    r = c;
      smx_pkg::SRC_PC:   r = p;
      smx_pkg::SRC_PC3:  r = p3;
      smx_pkg::SRC_PC6:  r = p6;
      smx_pkg::SRC_ONES: r = '1;
      default:           r = '0;
    endcase
    return r;
  endfunction

  // Configuration registers and the program counter. A start address write
  // also reloads the counter; user must only write when idle; not checked.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_q <= '0;
      pc_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        smx_pkg::CFG_ZERO_ADDR:  zero_q <= cfg_data_i[A-1:0];
        smx_pkg::CFG_START_ADDR: pc_q   <= W'(cfg_data_i[A-1:0]);
        default: ;
      endcase
    end else if (cmd_i.exec) begin
      pc_q <= pc_d;
    end
  end

  // Operand latches, loaded when a macro is taken.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_a_q <= operand_a_i;
      op_b_q <= operand_b_i;
      op_c_q <= operand_c_i;
    end
  end

  // Result register: it frees up when the consumer takes the triple.
  assign out_free_o = !out_valid_q || out_ready_i;
  assign load_out   = cmd_i.exec && cmd_i.ctrl.emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      word_a_q <= pick(cmd_i.ctrl.sel_a, z_word, op_a_q, op_b_q, op_c_q, pc_d, pc3, pc6);
      word_b_q <= pick(cmd_i.ctrl.sel_b, z_word, op_a_q, op_b_q, op_c_q, pc_d, pc3, pc6);
      word_c_q <= pick(cmd_i.ctrl.sel_c, z_word, op_a_q, op_b_q, op_c_q, pc_d, pc3, pc6);
      last_q   <= cmd_i.ctrl.done;
      bad_q    <= cmd_i.ctrl.bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign word_a_o    = word_a_q;
  assign word_b_o    = word_b_q;
  assign word_c_o    = word_c_q;
  assign last_o      = last_q;
  assign bad_args_o  = bad_q;

endmodule

`default_nettype wire

// ===== design/subleq_macro_expander_top.sv =====
// Top level of the SUBLEQ macro expander: joins the microcode sequencer and
// the datapath to the channels. Depends on smx_pkg, smx_if, smx_sequencer, smx_datapath.
`default_nettype none

// Each accepted macro-instruction is expanded into zero to four SUBLEQ
// triples by a short microprogram, one control word per clock cycle while
// no emitting step waits. A transaction is accepted and dispatched, then
// runs its microprogram steps: nop, subleq, sub, jmp, halt, data and an
// illegal argument count emit one triple, not and an unknown opcode emit
// none, add emits three and mov and beq four. The next transaction is
// accepted once the last step has run. Steps that emit a triple wait while
// the result register is full and not being taken. Configuration writes
// are accepted in every cycle and must only be issued while the block is
// idle; writing the start address also loads the program counter.
module subleq_macro_expander_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  smx_in_if.sink    item_i,
  smx_out_if.source result_o,
  smx_cfg_if.sink   cfg_i
);

  smx_pkg::seq_cmd_t cmd;
  logic              out_free;

  // Control: step counter and microcode table.
  smx_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (item_i.ready),
    .action_i    (item_i.action),
    .arg_count_i (item_i.arg_count),
    .out_free_i  (out_free),
    .cmd_o       (cmd)
  );

  // Data: registers, word selection and the result register.
  smx_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .out_free_o  (out_free),
    .operand_a_i (item_i.operand_a),
    .operand_b_i (item_i.operand_b),
    .operand_c_i (item_i.operand_c),
    .cfg_valid_i (cfg_i.valid),
    .cfg_index_i (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .word_a_o    (result_o.word_a),
    .word_b_o    (result_o.word_b),
    .word_c_o    (result_o.word_c),
    .last_o      (result_o.last),
    .bad_args_o  (result_o.bad_args)
  );

  // Configuration writes never stall.
  assign cfg_i.ready = 1'b1;

endmodule

`default_nettype wire
